// ===== sv/ectc_pkg.sv =====
// ----------------------------------------------------------------------------
// ectc_pkg: shared types and constants for the trace counter
// Field widths, micro-op encoding, command/status bundles and the micro-op ROM.
// ----------------------------------------------------------------------------
package ectc_pkg;

  localparam int FIELD_W     = 11;
  localparam int TRACE_W     = 13;
  localparam int EXP_W       = FIELD_W - 1;
  localparam int EBIT_W      = $clog2(EXP_W);
  localparam int CNT_W       = $clog2(FIELD_W);
  localparam int MAX_PRIME   = 2048;
  localparam int PRIME_RESET = 5;
  localparam int PRIME_MIN   = 3;
  localparam int PC_W        = 6;

  localparam logic [PC_W-1:0] SETUP_LAST = PC_W'(36);
  localparam logic [PC_W-1:0] FX_BASE    = PC_W'(37);
  localparam logic [PC_W-1:0] FX_LAST    = PC_W'(47);

  localparam logic [FIELD_W-1:0] K1  = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] K2  = FIELD_W'(2);
  localparam logic [FIELD_W-1:0] K4  = FIELD_W'(4);
  localparam logic [FIELD_W-1:0] K8  = FIELD_W'(8);
  localparam logic [FIELD_W-1:0] K9  = FIELD_W'(9);
  localparam logic [FIELD_W-1:0] K27 = FIELD_W'(27);

  typedef logic [FIELD_W-1:0] fe_t;

  typedef struct packed {
    fe_t coef_a1;
    fe_t coef_a2;
    fe_t coef_a3;
    fe_t coef_a4;
    fe_t coef_a6;
  } in_t;

  typedef struct packed {
    logic signed [TRACE_W-1:0] frobenius_trace;
    logic                      good_reduction;
  } out_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_K1, S_K2, S_K4, S_K8, S_K9, S_K27,
    S_A1, S_A2, S_A3, S_A4, S_A6,
    S_B2, S_B4, S_B6, S_B8, S_D,
    S_T0, S_T1, S_X, S_F, S_R
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP_ISSUE,
    ST_SETUP_WAIT,
    ST_FX_ISSUE,
    ST_FX_WAIT,
    ST_SQ_ISSUE,
    ST_SQ_WAIT,
    ST_PM_ISSUE,
    ST_PM_WAIT,
    ST_ACC,
    ST_DONE
  } state_t;

  // For OP_MUL, sa is the bit-serial operand (may be unreduced), sb must be < p.
  typedef struct packed {
    op_t  op;
    src_t dst;
    src_t sa;
    src_t sb;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              start;
    uop_t              uop;
    logic              acc;
    logic              inc_x;
    logic [EBIT_W-1:0] ebit;
  } cmd_t;

  typedef struct packed {
    logic op_idle;
    logic mod_bad;
    logic f_zero;
    logic x_last;
    logic exp_bit;
  } stat_t;

  // Setup: reduce coefficients, then b2/b4/b6/b8 and the discriminant.
  // Per x: f(x) = (a1*x+a3)^2 + 4*(((x+a2)*x+a4)*x+a6), then R = 1.
  function automatic uop_t rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:    u = '{OP_MUL, S_A1, S_A1, S_K1};
      6'd1:    u = '{OP_MUL, S_A2, S_A2, S_K1};
      6'd2:    u = '{OP_MUL, S_A3, S_A3, S_K1};
      6'd3:    u = '{OP_MUL, S_A4, S_A4, S_K1};
      6'd4:    u = '{OP_MUL, S_A6, S_A6, S_K1};
      6'd5:    u = '{OP_MUL, S_T0, S_A1, S_A1};
      6'd6:    u = '{OP_MUL, S_T1, S_K4, S_A2};
      6'd7:    u = '{OP_ADD, S_B2, S_T0, S_T1};
      6'd8:    u = '{OP_MUL, S_T0, S_A1, S_A3};
      6'd9:    u = '{OP_MUL, S_T1, S_K2, S_A4};
      6'd10:   u = '{OP_ADD, S_B4, S_T0, S_T1};
      6'd11:   u = '{OP_MUL, S_T0, S_A3, S_A3};
      6'd12:   u = '{OP_MUL, S_T1, S_K4, S_A6};
      6'd13:   u = '{OP_ADD, S_B6, S_T0, S_T1};
      6'd14:   u = '{OP_MUL, S_T0, S_B2, S_A6};
      6'd15:   u = '{OP_MUL, S_T1, S_A1, S_A3};
      6'd16:   u = '{OP_MUL, S_T1, S_T1, S_A4};
      6'd17:   u = '{OP_SUB, S_T0, S_T0, S_T1};
      6'd18:   u = '{OP_MUL, S_T1, S_A3, S_A3};
      6'd19:   u = '{OP_MUL, S_T1, S_A2, S_T1};
      6'd20:   u = '{OP_ADD, S_T0, S_T0, S_T1};
      6'd21:   u = '{OP_MUL, S_T1, S_A4, S_A4};
      6'd22:   u = '{OP_SUB, S_B8, S_T0, S_T1};
      6'd23:   u = '{OP_MUL, S_T0, S_B2, S_B2};
      6'd24:   u = '{OP_MUL, S_T0, S_T0, S_B8};
      6'd25:   u = '{OP_SUB, S_D,  S_ZERO, S_T0};
      6'd26:   u = '{OP_MUL, S_T1, S_B4, S_B4};
      6'd27:   u = '{OP_MUL, S_T1, S_T1, S_B4};
      6'd28:   u = '{OP_MUL, S_T1, S_K8, S_T1};
      6'd29:   u = '{OP_SUB, S_D,  S_D,  S_T1};
      6'd30:   u = '{OP_MUL, S_T1, S_B6, S_B6};
      6'd31:   u = '{OP_MUL, S_T1, S_K27, S_T1};
      6'd32:   u = '{OP_SUB, S_D,  S_D,  S_T1};
      6'd33:   u = '{OP_MUL, S_T1, S_B2, S_B4};
      6'd34:   u = '{OP_MUL, S_T1, S_T1, S_B6};
      6'd35:   u = '{OP_MUL, S_T1, S_K9, S_T1};
      6'd36:   u = '{OP_ADD, S_D,  S_D,  S_T1};
      6'd37:   u = '{OP_MUL, S_T0, S_A1, S_X};
      6'd38:   u = '{OP_ADD, S_T0, S_T0, S_A3};
      6'd39:   u = '{OP_MUL, S_T0, S_T0, S_T0};
      6'd40:   u = '{OP_ADD, S_T1, S_X,  S_A2};
      6'd41:   u = '{OP_MUL, S_T1, S_T1, S_X};
      6'd42:   u = '{OP_ADD, S_T1, S_T1, S_A4};
      6'd43:   u = '{OP_MUL, S_T1, S_T1, S_X};
      6'd44:   u = '{OP_ADD, S_T1, S_T1, S_A6};
      6'd45:   u = '{OP_MUL, S_T1, S_K4, S_T1};
      6'd46:   u = '{OP_ADD, S_F,  S_T0, S_T1};
      6'd47:   u = '{OP_ADD, S_R,  S_K1, S_ZERO};
      default: u = '{OP_ADD, S_ZERO, S_ZERO, S_ZERO};
    endcase
    return u;
  endfunction

endpackage

// ===== sv/elliptic_curve_trace_counter_top.sv =====
// ----------------------------------------------------------------------------
// elliptic_curve_trace_counter_top: Frobenius trace and reduction check
// Counts points of one Weierstrass curve mod p by summing quadratic characters.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive in_data with a1,a2,a3,a4,a6 and pulse start; the
//    transaction is taken on a clock edge with start high and busy low.
//  - busy stays high until the result is out; one curve at a time.
//  - Output: out_valid is high for exactly one cycle with out_data
//    (trace, good_reduction). The receiver cannot stall; capture it then.
//  - Config: cfg_valid/cfg_data write the modulus p (cfg_ready is always
//    high). Write only while busy is low. Reset value of p is 5.
//  - Timing: multiplies go through one bit-serial mod-p multiplier;
//    ADD/SUB use a combinational ALU. Setup reduces the coefficients
//    and forms b2/b4/b6/b8 and the discriminant. Each x skips the Euler
//    power when f(x)=0, else squares once per bit of (p-1)/2 and
//    multiplies by f once per set bit.
//  - Unsupported p (below 3 or above the max) returns 0/0.
//  - Reset (rst_n low, synchronous) returns the sequencer to idle.
// ----------------------------------------------------------------------------
module elliptic_curve_trace_counter_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ectc_pkg::in_t    in_data,
  output logic             out_valid,
  output ectc_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  ectc_pkg::fe_t    cfg_data
);

  ectc_pkg::cmd_t  cmd;
  ectc_pkg::stat_t stat;

  // modulus register is always writable
  assign cfg_ready = 1'b1;

  ectc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ectc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // result only while a transaction is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("out_valid while idle");

  // no micro-op is issued while a multiply is still running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> stat.op_idle)
    else $error("micro-op issued while multiplier busy");

endmodule

// ===== sv/ectc_modmul.sv =====
// ----------------------------------------------------------------------------
// ectc_modmul: bit-serial modular multiplier
// Interleaved shift-add, one bit of a per cycle, MSB first; b must be below m.
// ----------------------------------------------------------------------------
module ectc_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ectc_pkg::fe_t    a,
  input  ectc_pkg::fe_t    b,
  input  ectc_pkg::fe_t    m,
  output logic             busy,
  output logic             done,
  output ectc_pkg::fe_t    result
);

  localparam int W = ectc_pkg::FIELD_W;

  logic                         busy_r;
  logic [ectc_pkg::CNT_W-1:0]   cnt_r;
  ectc_pkg::fe_t                a_r;
  ectc_pkg::fe_t                b_r;
  ectc_pkg::fe_t                acc_r;
  ectc_pkg::fe_t                acc_nxt;
  logic [W+1:0]                 sum;
  logic [W+1:0]                 m1;
  logic [W+1:0]                 m2;

  // acc < m, so 2*acc + b < 3m: at most two subtractions
  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (a_r[cnt_r] ? {2'b00, b_r} : '0);
    if (sum >= m2) begin
      acc_nxt = W'(sum - m2);
    end else if (sum >= m1) begin
      acc_nxt = W'(sum - m1);
    end else begin
      acc_nxt = W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ectc_pkg::CNT_W'(W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign busy   = busy_r;
  assign done   = busy_r && (cnt_r == '0);
  assign result = acc_nxt;

endmodule

// ===== sv/ectc_datapath.sv =====
// ----------------------------------------------------------------------------
// ectc_datapath: operand registers, modular ALU and character accumulator
// Executes micro-ops from the controller; holds the modulus register.
// ----------------------------------------------------------------------------
module ectc_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  ectc_pkg::fe_t    cfg_value,
  input  ectc_pkg::in_t    in_data,
  input  ectc_pkg::cmd_t   cmd,
  output ectc_pkg::stat_t  stat,
  output ectc_pkg::out_t   out_data
);

  localparam int W = ectc_pkg::FIELD_W;

  ectc_pkg::fe_t prime_r;
  ectc_pkg::fe_t a1_r, a2_r, a3_r, a4_r, a6_r;
  ectc_pkg::fe_t b2_r, b4_r, b6_r, b8_r, d_r;
  ectc_pkg::fe_t t0_r, t1_r, x_r, f_r, r_r;
  logic signed [ectc_pkg::TRACE_W-1:0] sum_r;
  logic          bad_r;

  ectc_pkg::fe_t va, vb, alu_res, mul_res, pm1;
  ectc_pkg::src_t dst_r;
  logic [W:0]    add_s, sub_s, m_ext;
  logic          mul_busy, mul_done, mod_bad;
  logic [ectc_pkg::EXP_W-1:0] half;

  function automatic ectc_pkg::fe_t pick(
    input ectc_pkg::src_t s,
    input ectc_pkg::fe_t  ra1, ra2, ra3, ra4, ra6,
    input ectc_pkg::fe_t  rb2, rb4, rb6, rb8, rd,
    input ectc_pkg::fe_t  rt0, rt1, rx, rf, rr
  );
    ectc_pkg::fe_t v;
    unique case (s)
      ectc_pkg::S_ZERO: v = '0;
      ectc_pkg::S_K1:   v = ectc_pkg::K1;
      ectc_pkg::S_K2:   v = ectc_pkg::K2;
      ectc_pkg::S_K4:   v = ectc_pkg::K4;
      ectc_pkg::S_K8:   v = ectc_pkg::K8;
      ectc_pkg::S_K9:   v = ectc_pkg::K9;
      ectc_pkg::S_K27:  v = ectc_pkg::K27;
      ectc_pkg::S_A1:   v = ra1;
      ectc_pkg::S_A2:   v = ra2;
      ectc_pkg::S_A3:   v = ra3;
      ectc_pkg::S_A4:   v = ra4;
      ectc_pkg::S_A6:   v = ra6;
      ectc_pkg::S_B2:   v = rb2;
      ectc_pkg::S_B4:   v = rb4;
      ectc_pkg::S_B6:   v = rb6;
      ectc_pkg::S_B8:   v = rb8;
      ectc_pkg::S_D:    v = rd;
      ectc_pkg::S_T0:   v = rt0;
      ectc_pkg::S_T1:   v = rt1;
      ectc_pkg::S_X:    v = rx;
      ectc_pkg::S_F:    v = rf;
      ectc_pkg::S_R:    v = rr;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign va = pick(cmd.uop.sa, a1_r, a2_r, a3_r, a4_r, a6_r, b2_r, b4_r, b6_r, b8_r,
                   d_r, t0_r, t1_r, x_r, f_r, r_r);
  assign vb = pick(cmd.uop.sb, a1_r, a2_r, a3_r, a4_r, a6_r, b2_r, b4_r, b6_r, b8_r,
                   d_r, t0_r, t1_r, x_r, f_r, r_r);

  // both operands reduced for add/sub
  always_comb begin
    m_ext = {1'b0, prime_r};
    add_s = {1'b0, va} + {1'b0, vb};
    sub_s = {1'b0, va} + m_ext - {1'b0, vb};
    unique case (cmd.uop.op)
      ectc_pkg::OP_ADD: alu_res = (add_s >= m_ext) ? W'(add_s - m_ext) : W'(add_s);
      ectc_pkg::OP_SUB: alu_res = (va >= vb) ? (va - vb) : W'(sub_s);
      default:          alu_res = '0;
    endcase
  end

  ectc_modmul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start && (cmd.uop.op == ectc_pkg::OP_MUL)),
    .a      (va),
    .b      (vb),
    .m      (prime_r),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  logic          wr_en;
  ectc_pkg::src_t wr_dst;
  ectc_pkg::fe_t wr_val;

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = dst_r;
    wr_val = mul_res;
    if (mul_done) begin
      wr_en = 1'b1;
    end else if (cmd.start && (cmd.uop.op != ectc_pkg::OP_MUL)) begin
      wr_en  = 1'b1;
      wr_dst = cmd.uop.dst;
      wr_val = alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= W'(ectc_pkg::PRIME_RESET);
    end else if (cfg_we) begin
      prime_r <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dst_r <= cmd.uop.dst;
    end
    if (cmd.load) begin
      a1_r  <= in_data.coef_a1;
      a2_r  <= in_data.coef_a2;
      a3_r  <= in_data.coef_a3;
      a4_r  <= in_data.coef_a4;
      a6_r  <= in_data.coef_a6;
      x_r   <= '0;
      sum_r <= '0;
      bad_r <= mod_bad;
    end else begin
      if (wr_en) begin
        unique case (wr_dst)
          ectc_pkg::S_A1: a1_r <= wr_val;
          ectc_pkg::S_A2: a2_r <= wr_val;
          ectc_pkg::S_A3: a3_r <= wr_val;
          ectc_pkg::S_A4: a4_r <= wr_val;
          ectc_pkg::S_A6: a6_r <= wr_val;
          ectc_pkg::S_B2: b2_r <= wr_val;
          ectc_pkg::S_B4: b4_r <= wr_val;
          ectc_pkg::S_B6: b6_r <= wr_val;
          ectc_pkg::S_B8: b8_r <= wr_val;
          ectc_pkg::S_D:  d_r  <= wr_val;
          ectc_pkg::S_T0: t0_r <= wr_val;
          ectc_pkg::S_T1: t1_r <= wr_val;
          ectc_pkg::S_F:  f_r  <= wr_val;
          ectc_pkg::S_R:  r_r  <= wr_val;
          default: ;
        endcase
      end
      if (cmd.inc_x) begin
        x_r <= x_r + 1'b1;
      end
      if (cmd.acc && (f_r != '0)) begin
        sum_r <= (r_r == ectc_pkg::K1) ? sum_r + ectc_pkg::TRACE_W'(1) :
                                         sum_r - ectc_pkg::TRACE_W'(1);
      end
    end
  end

  assign mod_bad = (prime_r < W'(ectc_pkg::PRIME_MIN)) ||
                   (32'(prime_r) > ectc_pkg::MAX_PRIME);
  assign pm1     = prime_r - 1'b1;
  assign half    = pm1[W-1:1];

  assign stat.op_idle = !mul_busy;
  assign stat.mod_bad = mod_bad;
  assign stat.f_zero  = (f_r == '0);
  assign stat.x_last  = (x_r == pm1);
  assign stat.exp_bit = half[cmd.ebit];

  assign out_data.frobenius_trace = bad_r ? '0 : -sum_r;
  assign out_data.good_reduction  = !bad_r && (d_r != '0);

endmodule

// ===== sv/ectc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ectc_ctrl: sequencer for the trace counter
// Walks the micro-op ROM, the per-x loop and the MSB-first Euler power.
// ----------------------------------------------------------------------------
module ectc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ectc_pkg::stat_t  stat,
  output ectc_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid
);

  localparam int PW = ectc_pkg::PC_W;
  localparam int EW = ectc_pkg::EBIT_W;

  ectc_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]    pc_r, pc_nxt;
  logic [EW-1:0]    bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ectc_pkg::ST_IDLE;
      pc_r    <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    bit_nxt        = bit_r;
    cmd.load       = 1'b0;
    cmd.start      = 1'b0;
    cmd.uop        = ectc_pkg::rom(pc_r);
    cmd.acc        = 1'b0;
    cmd.inc_x      = 1'b0;
    cmd.ebit       = bit_r;
    busy           = (state_r != ectc_pkg::ST_IDLE);
    out_valid      = 1'b0;

    unique case (state_r)
      ectc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = stat.mod_bad ? ectc_pkg::ST_DONE : ectc_pkg::ST_SETUP_ISSUE;
        end
      end
      ectc_pkg::ST_SETUP_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = ectc_pkg::ST_SETUP_WAIT;
      end
      ectc_pkg::ST_SETUP_WAIT: begin
        if (stat.op_idle) begin
          if (pc_r == ectc_pkg::SETUP_LAST) begin
            pc_nxt = ectc_pkg::FX_BASE;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
          state_nxt = (pc_r == ectc_pkg::SETUP_LAST) ? ectc_pkg::ST_FX_ISSUE :
                                                     ectc_pkg::ST_SETUP_ISSUE;
        end
      end
      ectc_pkg::ST_FX_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = ectc_pkg::ST_FX_WAIT;
      end
      ectc_pkg::ST_FX_WAIT: begin
        if (stat.op_idle) begin
          if (pc_r == ectc_pkg::FX_LAST) begin
            bit_nxt   = EW'(ectc_pkg::EXP_W - 1);
            state_nxt = stat.f_zero ? ectc_pkg::ST_ACC : ectc_pkg::ST_SQ_ISSUE;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ectc_pkg::ST_FX_ISSUE;
          end
        end
      end
      ectc_pkg::ST_SQ_ISSUE: begin
        cmd.uop   = '{ectc_pkg::OP_MUL, ectc_pkg::S_R, ectc_pkg::S_R, ectc_pkg::S_R};
        cmd.start = 1'b1;
        state_nxt = ectc_pkg::ST_SQ_WAIT;
      end
      ectc_pkg::ST_SQ_WAIT, ectc_pkg::ST_PM_WAIT: begin
        if (stat.op_idle) begin
          if ((state_r == ectc_pkg::ST_SQ_WAIT) && stat.exp_bit) begin
            state_nxt = ectc_pkg::ST_PM_ISSUE;
          end else if (bit_r == '0) begin
            state_nxt = ectc_pkg::ST_ACC;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            state_nxt = ectc_pkg::ST_SQ_ISSUE;
          end
        end
      end
      ectc_pkg::ST_PM_ISSUE: begin
        cmd.uop   = '{ectc_pkg::OP_MUL, ectc_pkg::S_R, ectc_pkg::S_R, ectc_pkg::S_F};
        cmd.start = 1'b1;
        state_nxt = ectc_pkg::ST_PM_WAIT;
      end
      ectc_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (stat.x_last) begin
          state_nxt = ectc_pkg::ST_DONE;
        end else begin
          cmd.inc_x = 1'b1;
          pc_nxt    = ectc_pkg::FX_BASE;
          state_nxt = ectc_pkg::ST_FX_ISSUE;
        end
      end
      ectc_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ectc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ectc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for elliptic_curve_trace_counter_top
// Directed table then random curves, each checked against a typed-in answer or a
// behavioral point-count predictor with its own copy of the modulus register.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 90;
  localparam int IN_W           = $bits(ectc_pkg::in_t);

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  ectc_pkg::in_t   in_data;
  logic            out_valid;
  ectc_pkg::out_t  out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  ectc_pkg::fe_t   cfg_data;

  elliptic_curve_trace_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bench copy of the modulus register, updated when the write transaction lands.
  ectc_pkg::fe_t  modulus_shadow;
  ectc_pkg::out_t trace_queue[$];
  int             mismatch_cnt;
  int             stall_cnt;
  int             send_idle_pct;

  // Directed rows: modulus to run under, curve, and an optional typed-in answer.
  typedef struct {
    ectc_pkg::fe_t  prime;
    ectc_pkg::in_t  curve;
    bit             typed;
    ectc_pkg::out_t answer;
  } curve_row_t;

  // ---- predictor -----------------------------------------------------------
  function automatic int pow_mod(int base, int ex, int m);
    int acc;
    acc = 1 % m;
    base = base % m;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic ectc_pkg::out_t count_curve(ectc_pkg::fe_t prime, ectc_pkg::in_t c);
    ectc_pkg::out_t r;
    int   m, a1, a2, a3, a4, a6, half, sum, x, ln, x2, rhs, f;
    int   b2, b4, b6, b8, d;
    r = '0;
    m = prime;
    // unsupported modulus gives zero trace and bad reduction
    if (m < ectc_pkg::PRIME_MIN || m > ectc_pkg::MAX_PRIME) return r;
    a1 = c.coef_a1 % m;
    a2 = c.coef_a2 % m;
    a3 = c.coef_a3 % m;
    a4 = c.coef_a4 % m;
    a6 = c.coef_a6 % m;
    half = (m - 1) / 2;
    sum = 0;
    for (x = 0; x < m; x++) begin
      ln  = (a1 * x + a3) % m;
      x2  = (x * x) % m;
      rhs = ((x2 * x) % m + (a2 * x2) % m + (a4 * x) % m + a6) % m;
      f   = ((ln * ln) % m + (4 * rhs) % m) % m;
      // any Euler power other than 1 counts as a non-residue (composite p too)
      if (f != 0) sum += (pow_mod(f, half, m) == 1) ? 1 : -1;
    end
    b2 = (a1 * a1 + 4 * a2) % m;
    b4 = (a1 * a3 + 2 * a4) % m;
    b6 = (a3 * a3 + 4 * a6) % m;
    b8 = ((a1 * a1) % m * a6 + (4 * a2) % m * a6) % m;
    b8 = (b8 + m - ((a1 * a3) % m * a4) % m) % m;
    b8 = (b8 + (a2 * ((a3 * a3) % m)) % m) % m;
    b8 = (b8 + m - (a4 * a4) % m) % m;
    d = (m - ((b2 * b2) % m * b8) % m) % m;
    d = (d + m - (8 * ((b4 * b4) % m * b4 % m)) % m) % m;
    d = (d + m - (27 * ((b6 * b6) % m)) % m) % m;
    d = (d + ((9 * b2) % m * ((b4 * b6) % m)) % m) % m;
    r.frobenius_trace = ectc_pkg::TRACE_W'(-sum);
    r.good_reduction  = (d != 0);
    return r;
  endfunction

  // ---- drivers ---------------------------------------------------------------
  task automatic wait_drained();
    while (trace_queue.size() != 0) @(posedge clk);
  endtask

  // Modulus write: only with nothing in flight; every curve yields one result,
  // so an empty queue means the block is idle once busy drops.
  task automatic write_modulus(ectc_pkg::fe_t p);
    wait_drained();
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    modulus_shadow = p;
    cfg_valid <= 1'b0;
  endtask

  // One curve transaction; prediction is queued at the accepting edge.
  task automatic send_curve(ectc_pkg::in_t c, bit typed, ectc_pkg::out_t answer);
    ectc_pkg::out_t pred;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    pred = typed ? answer : count_curve(modulus_shadow, c);
    trace_queue = {trace_queue, pred};
    // drop start; busy rises after the accepting edge
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ectc_pkg::in_t rand_curve(ectc_pkg::fe_t p);
    ectc_pkg::in_t c;
    // mostly reduced coefficients; sometimes raw 11-bit values to force reduction
    if ($urandom_range(3, 0) == 0) begin
      c = IN_W'({$urandom, $urandom});
    end else begin
      c.coef_a1 = (p == 0) ? ectc_pkg::fe_t'($urandom) : ectc_pkg::fe_t'($urandom_range(p - 1, 0));
      c.coef_a2 = (p == 0) ? ectc_pkg::fe_t'($urandom) : ectc_pkg::fe_t'($urandom_range(p - 1, 0));
      c.coef_a3 = (p == 0) ? ectc_pkg::fe_t'($urandom) : ectc_pkg::fe_t'($urandom_range(p - 1, 0));
      c.coef_a4 = (p == 0) ? ectc_pkg::fe_t'($urandom) : ectc_pkg::fe_t'($urandom_range(p - 1, 0));
      c.coef_a6 = (p == 0) ? ectc_pkg::fe_t'($urandom) : ectc_pkg::fe_t'($urandom_range(p - 1, 0));
    end
    return c;
  endfunction

  // ---- result checker and watchdog --------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid) begin
        if (trace_queue.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: trace %0d good %0b",
                     out_data.frobenius_trace, out_data.good_reduction);
        end else begin
          ectc_pkg::out_t exp_r;
          exp_r = trace_queue.pop_front();
          if (out_data.frobenius_trace !== exp_r.frobenius_trace ||
              out_data.good_reduction  !== exp_r.good_reduction) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch p=%0d: trace exp %0d got %0d, good exp %0b got %0b",
                       modulus_shadow, exp_r.frobenius_trace, out_data.frobenius_trace,
                       exp_r.good_reduction, out_data.good_reduction);
          end
        end
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------------
  // small moduli keep the run short; unsupported and composite values are mixed in
  ectc_pkg::fe_t cheap_primes[10] = '{3, 5, 7, 11, 13, 0, 1, 2, 4, 9};

  curve_row_t rows[17] = '{
    // reset modulus, zero curve: f = 4x^3 sums to zero, singular
    '{5,    '0,               1'b1, '{13'sd0, 1'b0}},
    '{5,    '1,               1'b0, '0},
    '{5,    '{1, 0, 0, 0, 1}, 1'b0, '0},
    '{3,    '{0, 0, 0, 1, 0}, 1'b0, '0},
    '{3,    '1,               1'b0, '0},
    '{3,    '{2, 2, 2, 2, 2}, 1'b0, '0},
    // unsupported moduli return zero regardless of the curve
    '{0,    '1,               1'b1, '{13'sd0, 1'b0}},
    '{1,    '{1, 2, 3, 4, 5}, 1'b1, '{13'sd0, 1'b0}},
    '{2,    '1,               1'b1, '{13'sd0, 1'b0}},
    // even and composite moduli, then small primes
    '{4,    '{1, 3, 1, 2, 3}, 1'b0, '0},
    '{9,    '{0, 0, 0, 1, 1}, 1'b0, '0},
    '{9,    '1,               1'b0, '0},
    '{7,    '{0, 0, 0, 6, 0}, 1'b0, '0},
    '{7,    '{6, 6, 6, 6, 6}, 1'b0, '0},
    '{13,   '{0, 0, 0, 0, 12}, 1'b0, '0},
    // largest modulus, once
    '{2039, '{2038, 0, 2038, 1, 2038}, 1'b0, '0},
    '{5,    '{4, 4, 4, 4, 4}, 1'b0, '0}
  };

  initial begin
    curve_row_t    row;
    ectc_pkg::fe_t p;
    mismatch_cnt   = 0;
    stall_cnt      = 0;
    send_idle_pct  = 0;
    modulus_shadow = ectc_pkg::fe_t'(ectc_pkg::PRIME_RESET);
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.prime != modulus_shadow) write_modulus(row.prime);
      send_curve(row.curve, row.typed, row.answer);
    end

    // three random phases: light sender idling, heavy idling, none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 78 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 15 == 0) begin
          p = cheap_primes[$urandom_range(9, 0)];
          write_modulus(p);
        end
        send_curve(rand_curve(modulus_shadow), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && trace_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ectc_pkg.sv
sv/ectc_modmul.sv
sv/ectc_datapath.sv
sv/ectc_ctrl.sv
sv/elliptic_curve_trace_counter_top.sv
tb/sv/tb.sv
